// File: hw/rtl/qvr_pkg.sv
// Shared constants for the quaternion vector rotation core.
`timescale 1ns / 1ps

package qvr_pkg;

    // Default vector width in bits (sensor counts)
    localparam int VEC_WIDTH_DEF      = 16;
    // Default fraction bits of the quaternion (Q1.14)
    localparam int QUAT_FRAC_BITS_DEF = 14;
    // Width of each rotated output component
    localparam int OUT_WIDTH          = 18;

endpackage

// File: hw/rtl/quaternion_vector_rotate_core.sv
// Pipelined rotation of a vector by a fixed-point quaternion, r = q * (0,v) * conj(q).
`timescale 1ns / 1ps

// Channel  | Ports                                       | Handshake
// ---------+---------------------------------------------+------------------------------
// request  | quat_w/x/y/z, vec_x/y/z                     | beat taken when start && !busy
// result   | rot_x, rot_y, rot_z, clipped                | beat valid for one cycle on done
//
// One beat enters every cycle; busy is never raised.
// A result leaves through six register stages after its request beat is taken:
// input, first products, t sums, second products, r sums, output.
// Never stalls: the receiver must take every result in the cycle it shows (unchecked).
// Reset clears only the valid bits; payload registers carry no reset.

module quaternion_vector_rotate_core #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [QUAT_FRAC_BITS+1:0]  quat_w,
    input  logic signed [QUAT_FRAC_BITS+1:0]  quat_x,
    input  logic signed [QUAT_FRAC_BITS+1:0]  quat_y,
    input  logic signed [QUAT_FRAC_BITS+1:0]  quat_z,
    input  logic signed [VEC_WIDTH-1:0]       vec_x,
    input  logic signed [VEC_WIDTH-1:0]       vec_y,
    input  logic signed [VEC_WIDTH-1:0]       vec_z,
    output logic                              done,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_x,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_y,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_z,
    output logic                              clipped
);

    localparam int QW  = QUAT_FRAC_BITS + 2;           // quaternion width
    localparam int P1W = QW + VEC_WIDTH;               // q*v product
    localparam int TW  = P1W + 2;                      // t component
    localparam int P2W = TW + QW;                      // t*q product
    localparam int AW  = P2W + 2;                      // r component, exact
    localparam int FW  = (AW > 64) ? 64 : AW;          // r kept modulo 2^64
    localparam int PS  = 2 * QUAT_FRAC_BITS;           // fraction bits of r
    localparam int OW  = qvr_pkg::OUT_WIDTH;
    localparam int SW  = ((FW - PS) > OW) ? (FW - PS) : (OW + 1);
    localparam int NSTG = 6;

    localparam logic signed [FW-1:0] RND  = FW'(1) << (PS - 1);
    localparam logic signed [SW-1:0] S_HI = SW'((2 ** (OW - 1)) - 1);
    localparam logic signed [SW-1:0] S_LO = -S_HI - SW'(1);

    // Valid bits, one per stage
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // Stage 0: captured request
    logic signed [QW-1:0]        qw0_reg, qx0_reg, qy0_reg, qz0_reg;
    logic signed [VEC_WIDTH-1:0] vx0_reg, vy0_reg, vz0_reg;

    // Stage 1: q*v products and quaternion
    logic signed [P1W-1:0] m1_reg [12];
    logic signed [QW-1:0]  qw1_reg, qx1_reg, qy1_reg, qz1_reg;

    // Stage 2: t = q * (0, v)
    logic signed [TW-1:0]  tw_next, tx_next, ty_next, tz_next;
    logic signed [TW-1:0]  tw2_reg, tx2_reg, ty2_reg, tz2_reg;
    logic signed [QW-1:0]  qw2_reg, qx2_reg, qy2_reg, qz2_reg;

    // Stage 3: t*q products
    logic signed [P2W-1:0] m2_reg [12];

    // Stage 4: r = t * conj(q), vector part
    logic signed [AW-1:0]  r_next [3];
    logic signed [AW-1:0]  r4_reg [3];

    // Stage 5: rounded, saturated output
    logic signed [FW-1:0]  rnd_sum [3];
    logic signed [SW-1:0]  shf     [3];
    logic signed [OW-1:0]  sat_next [3];
    logic [2:0]            clip_bit;
    logic signed [OW-1:0]  rot_x_reg, rot_y_reg, rot_z_reg;
    logic                  clipped_reg;

    // Advance valid bits; a beat enters on every start
    assign vld_next = {vld_reg[NSTG-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qw0_reg <= quat_w;
            qx0_reg <= quat_x;
            qy0_reg <= quat_y;
            qz0_reg <= quat_z;
            vx0_reg <= vec_x;
            vy0_reg <= vec_y;
            vz0_reg <= vec_z;
        end
    end

    // Form the twelve q*v products
    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            m1_reg[0]  <= P1W'(qx0_reg) * P1W'(vx0_reg);
            m1_reg[1]  <= P1W'(qy0_reg) * P1W'(vy0_reg);
            m1_reg[2]  <= P1W'(qz0_reg) * P1W'(vz0_reg);
            m1_reg[3]  <= P1W'(qw0_reg) * P1W'(vx0_reg);
            m1_reg[4]  <= P1W'(qy0_reg) * P1W'(vz0_reg);
            m1_reg[5]  <= P1W'(qz0_reg) * P1W'(vy0_reg);
            m1_reg[6]  <= P1W'(qw0_reg) * P1W'(vy0_reg);
            m1_reg[7]  <= P1W'(qx0_reg) * P1W'(vz0_reg);
            m1_reg[8]  <= P1W'(qz0_reg) * P1W'(vx0_reg);
            m1_reg[9]  <= P1W'(qw0_reg) * P1W'(vz0_reg);
            m1_reg[10] <= P1W'(qx0_reg) * P1W'(vy0_reg);
            m1_reg[11] <= P1W'(qy0_reg) * P1W'(vx0_reg);
            qw1_reg    <= qw0_reg;
            qx1_reg    <= qx0_reg;
            qy1_reg    <= qy0_reg;
            qz1_reg    <= qz0_reg;
        end
    end

    // Sum the first Hamilton product
    always_comb
    begin
        tw_next = -TW'(m1_reg[0]) - TW'(m1_reg[1]) - TW'(m1_reg[2]);
        tx_next =  TW'(m1_reg[3]) + TW'(m1_reg[4]) - TW'(m1_reg[5]);
        ty_next =  TW'(m1_reg[6]) - TW'(m1_reg[7]) + TW'(m1_reg[8]);
        tz_next =  TW'(m1_reg[9]) + TW'(m1_reg[10]) - TW'(m1_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            tw2_reg <= tw_next;
            tx2_reg <= tx_next;
            ty2_reg <= ty_next;
            tz2_reg <= tz_next;
            qw2_reg <= qw1_reg;
            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
            qz2_reg <= qz1_reg;
        end
    end

    // Form the twelve t*q products
    always_ff @(posedge clk)
    begin
        if (vld_reg[2])
        begin
            m2_reg[0]  <= P2W'(tx2_reg) * P2W'(qw2_reg);
            m2_reg[1]  <= P2W'(tw2_reg) * P2W'(qx2_reg);
            m2_reg[2]  <= P2W'(ty2_reg) * P2W'(qz2_reg);
            m2_reg[3]  <= P2W'(tz2_reg) * P2W'(qy2_reg);
            m2_reg[4]  <= P2W'(ty2_reg) * P2W'(qw2_reg);
            m2_reg[5]  <= P2W'(tw2_reg) * P2W'(qy2_reg);
            m2_reg[6]  <= P2W'(tx2_reg) * P2W'(qz2_reg);
            m2_reg[7]  <= P2W'(tz2_reg) * P2W'(qx2_reg);
            m2_reg[8]  <= P2W'(tz2_reg) * P2W'(qw2_reg);
            m2_reg[9]  <= P2W'(tw2_reg) * P2W'(qz2_reg);
            m2_reg[10] <= P2W'(tx2_reg) * P2W'(qy2_reg);
            m2_reg[11] <= P2W'(ty2_reg) * P2W'(qx2_reg);
        end
    end

    // Sum the second Hamilton product, vector part only
    always_comb
    begin
        r_next[0] = AW'(m2_reg[0]) - AW'(m2_reg[1]) - AW'(m2_reg[2])  + AW'(m2_reg[3]);
        r_next[1] = AW'(m2_reg[4]) - AW'(m2_reg[5]) + AW'(m2_reg[6])  - AW'(m2_reg[7]);
        r_next[2] = AW'(m2_reg[8]) - AW'(m2_reg[9]) - AW'(m2_reg[10]) + AW'(m2_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[3])
        begin
            r4_reg[0] <= r_next[0];
            r4_reg[1] <= r_next[1];
            r4_reg[2] <= r_next[2];
        end
    end

    // Round half up, drop the fraction, saturate each component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_sum[i] = $signed(r4_reg[i][FW-1:0]) + RND;
            shf[i]     = SW'($signed(rnd_sum[i][FW-1:PS]));
            if (shf[i] > S_HI)
            begin
                sat_next[i] = OW'(S_HI);
                clip_bit[i] = 1'b1;
            end
            else if (shf[i] < S_LO)
            begin
                sat_next[i] = OW'(S_LO);
                clip_bit[i] = 1'b1;
            end
            else
            begin
                sat_next[i] = OW'(shf[i]);
                clip_bit[i] = 1'b0;
            end
        end
    end

    // Hold the result beat in the output register
    always_ff @(posedge clk)
    begin
        if (vld_reg[4])
        begin
            rot_x_reg   <= sat_next[0];
            rot_y_reg   <= sat_next[1];
            rot_z_reg   <= sat_next[2];
            clipped_reg <= |clip_bit;
        end
    end

    assign busy    = 1'b0;
    assign done    = vld_reg[NSTG-1];
    assign rot_x   = rot_x_reg;
    assign rot_y   = rot_y_reg;
    assign rot_z   = rot_z_reg;
    assign clipped = clipped_reg;

endmodule
